### src/mpv_pkg.sv
// ----------------------------------------------------------------------------
// mpv_pkg
// types, constants and sha-256 helpers for the merkle proof verifier
// ----------------------------------------------------------------------------
package mpv_pkg;

  localparam int HashWords = 4;

  typedef enum logic [1:0] {
    CMD_LEAF    = 2'd0,
    CMD_SIBLING = 2'd1,
    CMD_ROOT    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] hash_word_0;
    logic [63:0] hash_word_1;
    logic [63:0] hash_word_2;
    logic [63:0] hash_word_3;
  } in_word_t;

  typedef struct packed {
    logic        root_match;
    logic [63:0] computed_word_0;
    logic [63:0] computed_word_1;
    logic [63:0] computed_word_2;
    logic [63:0] computed_word_3;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLK1,
    ST_FOLD1,
    ST_BLK2,
    ST_FOLD2
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_leaf;   // running hash <= given hash
    logic capture;     // capture sibling, order pair, start block one
    logic start_pad;   // fold block one, start padding block
    logic round;       // one compression round
    logic commit;      // running hash <= digest
    logic make_out;    // register result word
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_round;
  } dp_stat_t;

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [511:0] PadBlock = {32'h80000000, 448'd0, 32'd512};

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### src/mpv_ctrl.sv
// ----------------------------------------------------------------------------
// mpv_ctrl
// command sequencer: decodes input words and steps the two compressions
// ----------------------------------------------------------------------------
module mpv_ctrl
  import mpv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic [1:0] in_cmd,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output dp_cmd_t  dp_cmd,
  input  dp_stat_t dp_stat
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    dp_cmd         = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    case (state)
      ST_IDLE: begin
        // a root report waits only while the previous report is still held
        in_ready = !(in_cmd == CMD_ROOT && out_valid && !out_ready);
        if (in_valid && in_ready) begin
          case (in_cmd)
            CMD_LEAF: dp_cmd.load_leaf = 1'b1;
            CMD_SIBLING: begin
              dp_cmd.capture = 1'b1;
              state_next     = ST_BLK1;
            end
            CMD_ROOT: begin
              dp_cmd.make_out = 1'b1;
              out_valid_next  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_BLK1: begin
        dp_cmd.round = 1'b1;
        if (dp_stat.last_round) state_next = ST_FOLD1;
      end
      ST_FOLD1: begin
        dp_cmd.start_pad = 1'b1;
        state_next       = ST_BLK2;
      end
      ST_BLK2: begin
        dp_cmd.round = 1'b1;
        if (dp_stat.last_round) state_next = ST_FOLD2;
      end
      ST_FOLD2: begin
        dp_cmd.commit = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### src/mpv_datapath.sv
// ----------------------------------------------------------------------------
// mpv_datapath
// running hash, pair ordering and a one-round-per-cycle sha-256 core
// ----------------------------------------------------------------------------
module mpv_datapath
  import mpv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_word,
  input  dp_cmd_t   dp_cmd,
  output dp_stat_t  dp_stat,
  output out_word_t out_word
);

  logic [255:0] running;     // running hash, byte 0 in msbs
  logic [255:0] chain;       // chaining value h0..h7
  logic [255:0] work;        // a..h
  logic [31:0]  sched [16];  // message schedule window
  logic [5:0]   rnd;
  logic [255:0] given;
  logic [511:0] pair_blk;
  logic [31:0]  a, b, c, d, e, f, g, h, t1, t2, w_new, s0, s1;
  logic [255:0] folded;

  assign given = {in_word.hash_word_0, in_word.hash_word_1,
                  in_word.hash_word_2, in_word.hash_word_3};
  // unsigned byte order equals plain 256-bit compare
  assign pair_blk = (running < given) ? {running, given} : {given, running};

  assign {a, b, c, d, e, f, g, h} = work;
  assign t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + round_k(rnd) + sched[0];
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  assign s0 = rotr(sched[1], 7) ^ rotr(sched[1], 18) ^ (sched[1] >> 3);
  assign s1 = rotr(sched[14], 17) ^ rotr(sched[14], 19) ^ (sched[14] >> 10);
  assign w_new = sched[0] + s0 + sched[9] + s1;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      folded[255 - 32*i -: 32] = chain[255 - 32*i -: 32] + work[255 - 32*i -: 32];
    end
  end

  assign dp_stat.last_round = (rnd == 6'd63);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
      rnd     <= '0;
    end else begin
      if (dp_cmd.load_leaf) running <= given;
      if (dp_cmd.commit) running <= folded;
      if (dp_cmd.round) rnd <= rnd + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      chain <= InitH;
      work  <= InitH;
      for (int i = 0; i < 16; i++) sched[i] <= pair_blk[511 - 32*i -: 32];
    end else if (dp_cmd.start_pad) begin
      chain <= folded;
      work  <= folded;
      for (int i = 0; i < 16; i++) sched[i] <= PadBlock[511 - 32*i -: 32];
    end else if (dp_cmd.round) begin
      work <= {t1 + t2, a, b, c, d + t1, e, f, g};
      for (int i = 0; i < 15; i++) sched[i] <= sched[i+1];
      sched[15] <= w_new;
    end
    if (dp_cmd.make_out) begin
      out_word.root_match      <= (running == given);
      out_word.computed_word_0 <= running[255:192];
      out_word.computed_word_1 <= running[191:128];
      out_word.computed_word_2 <= running[127:64];
      out_word.computed_word_3 <= running[63:0];
    end
  end

endmodule

### src/merkle_proof_verifier.sv
// ----------------------------------------------------------------------------
// merkle_proof_verifier
// sorted-pair sha-256 merkle inclusion proof checker
// ----------------------------------------------------------------------------
//  channel | signals                     | carries
//  in      | in_valid, in_ready, in_word | command and 256-bit hash
//  out     | out_valid, out_ready, out_word | match flag and running hash
//
//  root: the report is valid from the next cycle, held until out_ready
//  sibling: two 64-round compressions on one round unit plus folds
//  in_ready is low while a sibling is hashed, and for a root while the
//  previous report still waits; other commands pass a waiting report
//  reset clears the running hash to zero and returns the sequencer to idle
// ----------------------------------------------------------------------------
module merkle_proof_verifier
  import mpv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer
  mpv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_cmd    (in_word.cmd),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  // hash state and round unit
  mpv_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat),
    .out_word (out_word)
  );

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sorted-pair sha-256 merkle proof verifier
// ----------------------------------------------------------------------------
// words go in through a valid/ready sender task; a software sha-256 predictor
// keeps its own running hash and queues the expected root reports, which a
// monitor process compares field by field as they leave the block
// ----------------------------------------------------------------------------
module tb;
  import mpv_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  merkle_proof_verifier i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // predictor state and the queue of root reports still to come
  logic [255:0] model_hash;
  out_word_t    root_reports[$];
  int           n_errors;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_cycles;

  localparam logic [31:0] KTab[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one sha-256 compression of a 512-bit block into the chaining value
  function automatic logic [255:0] sha_block(logic [255:0] chain, logic [511:0] blk);
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] s0, s1, t1, t2;
    logic [255:0] res;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain[255 - 32*i -: 32];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) res[255 - 32*i -: 32] = chain[255 - 32*i -: 32] + v[i];
    return res;
  endfunction

  // advance the proof state by one accepted word
  function automatic void predict_proof_step(in_word_t w);
    logic [255:0] given;
    logic [255:0] lo, hi;
    out_word_t    rep;
    given = {w.hash_word_0, w.hash_word_1, w.hash_word_2, w.hash_word_3};
    case (cmd_t'(w.cmd))
      CMD_LEAF: model_hash = given;
      CMD_SIBLING: begin
        // plain unsigned compare equals byte-wise order with byte 0 on top
        if (model_hash < given) begin
          lo = model_hash; hi = given;
        end else begin
          lo = given; hi = model_hash;
        end
        model_hash = sha_block(sha_block(InitH, {lo, hi}), PadBlock);
      end
      CMD_ROOT: begin
        rep.root_match = (model_hash == given);
        {rep.computed_word_0, rep.computed_word_1,
         rep.computed_word_2, rep.computed_word_3} = model_hash;
        root_reports.insert(root_reports.size(), rep);
      end
      default: ;
    endcase
  endfunction

  // offer one word, with random idle cycles first, and wait for acceptance;
  // valid stays up after acceptance until the next word or an idle cycle
  task automatic send_word(logic [1:0] c, logic [255:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_word <= {c, h};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_proof_step({c, h});
    @(negedge clk);
  endtask

  function automatic logic [255:0] rand_hash();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // receiver side: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (root_reports.size() == 0) begin
        $display("%0t: unexpected result exp none got %h", $time, out_word);
        n_errors++;
      end else begin
        want = root_reports.pop_front();
        if (out_word.root_match !== want.root_match) begin
          $display("%0t: root_match exp %b got %b", $time, want.root_match,
                   out_word.root_match);
          n_errors++;
        end
        if (out_word.computed_word_0 !== want.computed_word_0) begin
          $display("%0t: word_0 exp %h got %h", $time, want.computed_word_0,
                   out_word.computed_word_0);
          n_errors++;
        end
        if (out_word.computed_word_1 !== want.computed_word_1) begin
          $display("%0t: word_1 exp %h got %h", $time, want.computed_word_1,
                   out_word.computed_word_1);
          n_errors++;
        end
        if (out_word.computed_word_2 !== want.computed_word_2) begin
          $display("%0t: word_2 exp %h got %h", $time, want.computed_word_2,
                   out_word.computed_word_2);
          n_errors++;
        end
        if (out_word.computed_word_3 !== want.computed_word_3) begin
          $display("%0t: word_3 exp %h got %h", $time, want.computed_word_3,
                   out_word.computed_word_3);
          n_errors++;
        end
      end
    end
  end

  // directed: reset hash, extremes, ties, unused code, root leaves hash alone
  task automatic test_directed();
    logic [255:0] ones;
    logic [255:0] x;
    ones = '1;
    send_word(CMD_ROOT, '0);            // reset hash reported, matches zero
    send_word(CMD_SIBLING, ones);       // sibling before any leaf
    send_word(CMD_ROOT, ones);
    send_word(CMD_LEAF, ones);
    send_word(CMD_ROOT, ones);
    send_word(CMD_SIBLING, '0);         // smaller sibling goes first
    send_word(CMD_ROOT, model_hash);    // root gives the exact hash
    send_word(CMD_ROOT, model_hash);    // and leaves it unchanged
    x = rand_hash();
    send_word(CMD_LEAF, x);
    send_word(CMD_SIBLING, x);          // tie
    send_word(CMD_NONE, ones);          // unused code ignored
    send_word(CMD_ROOT, model_hash ^ 256'h1);
    send_word(CMD_LEAF, {8'h80, 248'h0});
    send_word(CMD_SIBLING, {8'h7f, 248'h0}); // differs in byte 0 only
    send_word(CMD_SIBLING, {248'h0, 8'h01});
    send_word(CMD_NONE, '0);
    send_word(CMD_ROOT, '0);
  endtask

  // proofs of random depth against right and wrong roots, plus some noise
  task automatic test_proofs(int n_words);
    int sent;
    int depth;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(9) == 0) begin
        send_word(2'($urandom_range(3)), rand_hash());
        sent++;
      end else begin
        depth = $urandom_range(0, 4);
        send_word(CMD_LEAF, rand_hash());
        for (int d = 0; d < depth; d++) send_word(CMD_SIBLING, rand_hash());
        if ($urandom_range(1)) send_word(CMD_ROOT, model_hash);
        else send_word(CMD_ROOT, model_hash ^ (256'h1 << $urandom_range(255)));
        sent += depth + 2;
      end
    end
  endtask

  // receiver stalls for a long stretch while words keep coming
  task automatic test_backpressure();
    hold_cycles = 600;
    for (int i = 0; i < 12; i++) send_word(CMD_ROOT, rand_hash());
    test_proofs(20);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    n_errors = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    model_hash = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    send_idle_pct = 31; recv_idle_pct = 71;
    test_proofs(360);
    test_backpressure();
    send_idle_pct = 71; recv_idle_pct = 31;
    test_proofs(360);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_proofs(360);
    in_valid <= 1'b0;
    while (root_reports.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
src/mpv_pkg.sv
src/mpv_ctrl.sv
src/mpv_datapath.sv
src/merkle_proof_verifier.sv
dv/tb.sv
